// ===== rtl/xs1024_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// xs1024_pkg
// Shared types, constants and the state mixing function of the xorshift1024*
// generator.
// ============================================================================
package xs1024_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned HALF_W     = WORD_W / 2;
    localparam int unsigned WORD_COUNT = 16;
    localparam int unsigned POS_W      = $clog2(WORD_COUNT);

    localparam int unsigned SHIFT_A = 31;
    localparam int unsigned SHIFT_B = 11;
    localparam int unsigned SHIFT_C = 30;

    // Output multiplier, odd 64-bit constant
    localparam logic [WORD_W-1:0] MULT = 64'h1066_89D4_5497_FDB5;
    localparam logic [HALF_W-1:0] MULT_LO = MULT[HALF_W-1:0];
    localparam logic [HALF_W-1:0] MULT_HI = MULT[WORD_W-1:HALF_W];

    // Request codes
    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [POS_W-1:0]  t_pos;

    // Mixed word handed from front to queue
    typedef struct packed {
        logic  valid;
        t_word data;
    } t_push;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // xorshift step: s1 is the word after the pointer, s0 the word at it
    function automatic t_word xs_mix(input t_word s0, input t_word s1);
        t_word t;
        t = s1 ^ (s1 << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        return t ^ s0 ^ (s0 >> SHIFT_C);
    endfunction

endpackage

// ===== rtl/xs1024_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// xs1024_front
// Accepts request beats, holds the sixteen state words as a rotating line
// (slot 0 is always the word at the pointer) and produces one mixed word per
// draw. Loads write one slot, addressed relative to the pointer.
// ============================================================================
module xs1024_front
    import xs1024_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [3:0]  i_load_index,
    input  logic [63:0] i_load_value,
    input  t_fifo_stat  i_fifo_stat,
    output t_push       o_push
);

    t_word r_words [WORD_COUNT];
    t_word n_words [WORD_COUNT];
    t_pos  r_pos;
    t_pos  n_pos;
    t_pos  w_slot;
    t_word w_mixed;
    logic  w_accept;

    assign o_in_stall = i_fifo_stat.full;
    assign w_accept   = i_in_valid && !i_fifo_stat.full;
    assign w_slot     = t_pos'(i_load_index) - r_pos;
    assign w_mixed    = xs_mix(r_words[0], r_words[1]);

    // Next state of the word line and pointer
    always_comb begin
        n_words = r_words;
        n_pos   = r_pos;
        if (w_accept) begin
            if (i_req_type == REQ_LOAD) begin
                n_words[w_slot] = i_load_value;
            end else begin
                // rotate by one, mixed word lands at the new pointer
                n_words[0] = w_mixed;
                for (int i = 1; i < WORD_COUNT - 1; i++) begin
                    n_words[t_pos'(i)] = r_words[t_pos'(i + 1)];
                end
                n_words[t_pos'(WORD_COUNT - 1)] = r_words[0];
                n_pos = r_pos + t_pos'(1);
            end
        end
    end

    // Push mixed word on every accepted draw
    always_comb begin
        o_push.valid = w_accept && (i_req_type == REQ_DRAW);
        o_push.data  = w_mixed;
    end

    // State words carry no reset
    always_ff @(posedge i_clk) begin
        r_words <= n_words;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // Pointer steps by one on a draw
    a_pos_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req_type == REQ_DRAW) |=> (r_pos == t_pos'($past(r_pos) + 1'b1)))
        else $error("pointer did not advance on draw");

    // Pointer holds on a load
    a_pos_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req_type == REQ_LOAD) |=> $stable(r_pos))
        else $error("pointer moved on load");

    // A draw always lands in the queue
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req_type == REQ_DRAW) |-> o_push.valid)
        else $error("draw beat not pushed");

endmodule

// ===== rtl/xs1024_fifo.sv =====
`timescale 1ns / 1ps
// ============================================================================
// xs1024_fifo
// Short queue of mixed words between the front and the multiplier back end.
// ============================================================================
module xs1024_fifo
    import xs1024_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    input  logic       i_pop,
    output t_fifo_stat o_stat,
    output t_word      o_rd_data
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_word              r_mem [DEPTH];
    logic [IDX_W-1:0]   r_wr;
    logic [IDX_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic               w_push;
    logic               w_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push.valid && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_rd_data    = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + IDX_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + IDX_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push.valid && o_stat.full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count out of range");

endmodule

// ===== rtl/xs1024_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// xs1024_back
// Two-stage 64x64 (mod 2^64) multiply by the output constant, built from
// three 32x32 partial products, with the output beat register at the end.
// ============================================================================
module xs1024_back
    import xs1024_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_fifo_stat  i_fifo_stat,
    input  t_word       i_rd_data,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_random_value
);

    logic              w_en;
    logic              r_s1_valid;
    logic [WORD_W-1:0] r_p0;
    logic [HALF_W-1:0] r_p1;
    logic [HALF_W-1:0] r_p2;
    logic [HALF_W-1:0] w_a_lo;
    logic [HALF_W-1:0] w_a_hi;
    logic [HALF_W-1:0] w_cross;
    logic              r_out_valid;
    t_word             r_out_data;

    // Whole back end moves when the output register is free
    assign w_en   = !r_out_valid || !i_out_stall;
    assign o_pop  = w_en && !i_fifo_stat.empty;
    assign w_a_lo = i_rd_data[HALF_W-1:0];
    assign w_a_hi = i_rd_data[WORD_W-1:HALF_W];
    assign w_cross = r_p1 + r_p2;

    // Stage 1: partial products, only the low half of the cross terms matters
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0 <= WORD_W'(w_a_lo) * WORD_W'(MULT_LO);
            r_p1 <= HALF_W'(w_a_lo * MULT_HI);
            r_p2 <= HALF_W'(w_a_hi * MULT_LO);
        end
    end

    // Stage 2: final sum into the output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= r_p0 + {w_cross, {HALF_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= o_pop;
            r_out_valid <= r_s1_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_random_value = r_out_data;

    // A stage-1 word moves to the output when the back end advances
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_en) |=> r_out_valid)
        else $error("stage 1 beat lost");

    // A popped word always enters stage 1
    a_pop_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_s1_valid)
        else $error("popped beat lost");

    // Stage 1 holds while the output is stalled
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_s1_valid))
        else $error("stage 1 changed under stall");

endmodule

// ===== rtl/xorshift1024_star_generator_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// xorshift1024_star_generator_core
// xorshift1024* random generator: sixteen 64-bit state words, a 4-bit pointer
// and a 64-bit output multiply.
//
// Usage:
//   Request channel (i_in_valid / o_in_stall): i_req_type selects a draw
//   (REQ_DRAW) or a load (REQ_LOAD) of state word i_load_index. Load all
//   sixteen words before the first draw. Loads produce no output beat.
//   Result channel (o_out_valid / i_out_stall): one o_random_value beat per
//   draw, in request order.
//   Throughput: one request per cycle while the queue is not full. The
//   state update (read two words, mix, write back) is combinational into a
//   rotating register line; the multiply sits after a small queue, off that
//   loop. A draw goes from the queue to the stage-1 and output registers.
//   Stall: when the receiver stalls, the multiply pipeline holds and the
//   queue (FIFO_DEPTH beats) fills; once full, o_in_stall rises.
//   Reset: clears the pointer, queue and valid flags. State words are not
//   cleared and must be loaded.
// ============================================================================
module xorshift1024_star_generator_core
    import xs1024_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [3:0]  i_load_index,
    input  logic [63:0] i_load_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_random_value
);

    t_push      w_push;
    t_fifo_stat w_fifo_stat;
    t_word      w_rd_data;
    logic       w_pop;

    // Front: state line and mixing
    xs1024_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_load_index (i_load_index),
        .i_load_value (i_load_value),
        .i_fifo_stat  (w_fifo_stat),
        .o_push       (w_push)
    );

    // Queue between front and back
    xs1024_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_pop     (w_pop),
        .o_stat    (w_fifo_stat),
        .o_rd_data (w_rd_data)
    );

    // Back: output multiply
    xs1024_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fifo_stat    (w_fifo_stat),
        .i_rd_data      (w_rd_data),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_random_value (o_random_value)
    );

endmodule

// ===== sim/tb_xorshift1024_star_generator_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_xorshift1024_star_generator_core
// Self-checking bench for the xorshift1024* generator core. All sixteen state
// words are loaded before any draw, then random mixes of draws and reloads
// run through four idling phases. A local copy of the generator predicts
// every draw result, and the bench compares each output beat in order.
// ============================================================================
module tb_xorshift1024_star_generator_core;
    import xs1024_pkg::*;

    localparam logic [63:0] STAR_MULT     = 64'd1181783497276652981;
    localparam int          RANDOM_ITEMS  = 800;
    localparam int          PHASE_ITEMS   = RANDOM_ITEMS / 4;
    localparam int          LONG_HOLD     = 200;
    localparam int          WATCHDOG_MAX  = 3000;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          REPORT_MAX    = 10;

    typedef enum logic [1:0] {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } t_phase;

    typedef struct {
        logic        req_type;
        logic [3:0]  index;
        logic [63:0] value;
    } t_req;

    // DUT ports; inputs known from time zero
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        i_req_type     = REQ_LOAD;
    logic [3:0]  i_load_index   = '0;
    logic [63:0] i_load_value   = '0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [63:0] o_random_value;

    // Bench state
    t_req        req_queue[$];
    logic [63:0] draw_expq[$];
    logic [63:0] gen_words[16];
    logic [3:0]  gen_pos;
    t_phase      phase          = PH_FREE;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          out_beats      = 0;
    int          errors         = 0;
    int          hold_left      = 0;
    bit          hold_done      = 1'b0;
    int          quiet_cycles   = 0;

    xorshift1024_star_generator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_load_index   (i_load_index),
        .i_load_value   (i_load_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_random_value (o_random_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Generator copy: apply one accepted request, queue the draw result
    task automatic gen_apply(input logic req_type, input logic [3:0] index,
                             input logic [63:0] value);
        logic [63:0] s0;
        logic [63:0] s1;
        if (req_type == REQ_LOAD) begin
            gen_words[index] = value;
        end else begin
            s0 = gen_words[gen_pos];
            gen_pos = gen_pos + 4'd1;
            s1 = gen_words[gen_pos];
            s1 = s1 ^ (s1 << 31);
            s1 = s1 ^ (s1 >> 11);
            s1 = s1 ^ s0 ^ (s0 >> 30);
            gen_words[gen_pos] = s1;
            draw_expq.push_back(s1 * STAR_MULT);
        end
    endtask

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        case ($urandom_range(9))
            0: w = '0;
            1: w = '1;
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    // Mostly draws; reloads mid-stream keep the pointer where it is
    function automatic t_req rand_req();
        t_req r;
        r.req_type = ($urandom_range(99) < 15) ? REQ_LOAD : REQ_DRAW;
        r.index    = 4'($urandom_range(15));
        r.value    = rand_word();
        return r;
    endfunction

    function automatic t_req mk_req(input logic req_type, input logic [3:0] index,
                                    input logic [63:0] value);
        t_req r;
        r.req_type = req_type;
        r.index    = index;
        r.value    = value;
        return r;
    endfunction

    // Request driver: holds a stalled beat, otherwise offers the next one
    always @(posedge i_clk) begin : drv
        t_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                gen_apply(i_req_type, i_load_index, i_load_value);
            end
            if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = req_queue.pop_front();
                i_in_valid   <= 1'b1;
                i_req_type   <= nxt.req_type;
                i_load_index <= nxt.index;
                i_load_value <= nxt.value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, with one long hold-off so the core backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && phase == PH_FREE && out_beats >= 20) begin
            hold_done   <= 1'b1;
            hold_left   <= LONG_HOLD;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result monitor: each beat against the oldest expected draw
    always @(posedge i_clk) begin : mon
        logic [63:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            out_beats <= out_beats + 1;
            if (draw_expq.size() == 0) begin
                errors <= errors + 1;
                if (errors < REPORT_MAX)
                    $display("unexpected beat: random_value=%h", o_random_value);
            end else begin
                want = draw_expq.pop_front();
                if (o_random_value !== want) begin
                    errors <= errors + 1;
                    if (errors < REPORT_MAX)
                        $display("mismatch beat %0d: random_value expected %h got %h",
                                 out_beats, want, o_random_value);
                end
            end
        end
    end

    // Watchdog: too long without any beat on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("timeout: %0d results still expected", draw_expq.size());
            $display("tb_xorshift1024_star_generator_core NOT OK");
            $finish;
        end
    end

    task automatic wait_idle();
        while (req_queue.size() > 0 || i_in_valid || draw_expq.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin : stim
        int k;
        logic [63:0] seeds[16];
        gen_pos = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes into all sixteen words, then draws
        seeds[0]  = '0;
        seeds[1]  = '1;
        seeds[2]  = 64'd1;
        seeds[3]  = 64'h8000_0000_0000_0000;
        seeds[4]  = 64'hAAAA_AAAA_AAAA_AAAA;
        seeds[5]  = 64'h5555_5555_5555_5555;
        seeds[6]  = 64'h0000_0000_FFFF_FFFF;
        seeds[7]  = 64'hFFFF_FFFF_0000_0000;
        for (k = 8; k < 16; k++)
            seeds[4'(k)] = {$urandom, $urandom};
        for (k = 15; k >= 0; k--)
            req_queue.push_back(mk_req(REQ_LOAD, 4'(k), seeds[4'(k)]));
        // Draws ignore the load fields, so give them extreme junk
        req_queue.push_back(mk_req(REQ_DRAW, 4'hF, '1));
        req_queue.push_back(mk_req(REQ_DRAW, 4'h0, '0));
        for (k = 0; k < 7; k++)
            req_queue.push_back(mk_req(REQ_DRAW, 4'($urandom_range(15)), rand_word()));
        wait_idle();

        // Random part, one chunk per idling phase
        for (k = 0; k < 4; k++) begin
            phase = t_phase'(k);
            case (phase)
                PH_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                PH_SEND_IDLE:  begin send_idle_pct = 80; recv_stall_pct = 0;  end
                PH_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default:       begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            repeat (PHASE_ITEMS) req_queue.push_back(rand_req());
            // Sender pauses here until every result is in
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (draw_expq.size() != 0)
            errors = errors + 1;
        if (errors == 0)
            $display("tb_xorshift1024_star_generator_core OK");
        else
            $display("tb_xorshift1024_star_generator_core NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/xs1024_pkg.sv
rtl/xs1024_front.sv
rtl/xs1024_fifo.sv
rtl/xs1024_back.sv
rtl/xorshift1024_star_generator_core.sv
sim/tb_xorshift1024_star_generator_core.sv
